// File: hdl/mexp_pkg.sv
package mexp_pkg;

  // operand and result width
  localparam int unsigned Width = 32;
  // bit counter width for one shift-add pass
  localparam int unsigned CntW = $clog2(Width);

  // operation run by the shift-add unit
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_REDUCE = 2'd1,
    OP_MUL_R  = 2'd2,
    OP_MUL_S  = 2'd3
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture a new request
    logic setup;     // clear accumulator, load multiplier from square
    logic iterate;   // run one shift-add step
    op_e  op;        // operation being stepped
    logic out_load;  // move result into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic special;   // zero exponent or zero modulus, no loop needed
    logic last;      // final step of the current pass
    logic exp_lsb;   // current exponent bit
    logic exp_more;  // exponent bits left above the current one
  } sts_t;

endpackage

// File: hdl/modular_exponentiation_core.sv
// Modular exponentiation: returns base_value to the power exponent, reduced
// modulo modulus, all 32-bit unsigned. A zero exponent gives 1 for any
// modulus; a zero modulus with a nonzero exponent gives 0 and raises
// zero_modulus_error on tuser. One request is worked on at a time by
// right-to-left square-and-multiply, where every modular product runs on one
// shared shift-add reducer, with a setup step before each product. The result
// sits in an output register, so the next request is accepted while it waits.
module modular_exponentiation_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // base_value [31:0], exponent [63:32], modulus [95:64]
  input  logic [3*mexp_pkg::Width-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // power_result [31:0]
  output logic [mexp_pkg::Width-1:0]    m_axis_tdata_o,
  // zero_modulus_error [0]
  output logic                          m_axis_tuser_o
);

  mexp_pkg::cmd_t cmd;
  mexp_pkg::sts_t sts;

  // sequencer
  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // operand registers and shift-add reducer
  mexp_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .in_data_i            (s_axis_tdata_i),
    .power_result_o       (m_axis_tdata_o),
    .zero_modulus_error_o (m_axis_tuser_o)
  );

endmodule

// File: hdl/mexp_dp.sv
module mexp_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mexp_pkg::cmd_t                cmd_i,
  output mexp_pkg::sts_t                sts_o,
  input  logic [3*mexp_pkg::Width-1:0]  in_data_i,
  output logic [mexp_pkg::Width-1:0]    power_result_o,
  output logic                          zero_modulus_error_o
);

  localparam int unsigned W = mexp_pkg::Width;

  logic [W-1:0]   base_in, exp_in, mod_in;
  logic [W-1:0]   mod_q, sq_q, sq_d, res_q, res_d, exp_q, exp_d;
  logic [W-1:0]   acc_q, acc_d, b_q, b_d;
  logic [mexp_pkg::CntW-1:0] cnt_q, cnt_d;
  logic           special_q, special_d, err_q, err_d;
  logic [W-1:0]   addend, step;
  logic [W+1:0]   sum;
  logic [W+2:0]   sub1, sub2;
  logic [W-1:0]   out_res_q;
  logic           out_err_q;
  logic           exp_zero, mod_zero;

  assign base_in = in_data_i[W-1:0];
  assign exp_in  = in_data_i[2*W-1:W];
  assign mod_in  = in_data_i[3*W-1:2*W];
  assign exp_zero = (exp_in == '0);
  assign mod_zero = (mod_in == '0);

  // one shift-add step: 2*acc plus addend, reduced below the modulus
  always_comb begin
    case (cmd_i.op)
      mexp_pkg::OP_REDUCE: addend = {{(W-1){1'b0}}, b_q[W-1]};
      mexp_pkg::OP_MUL_R:  addend = b_q[W-1] ? res_q : '0;
      mexp_pkg::OP_MUL_S:  addend = b_q[W-1] ? sq_q : '0;
      default:             addend = '0;
    endcase
    sum  = {1'b0, acc_q, 1'b0} + {2'b00, addend};
    sub1 = {1'b0, sum} - {3'b000, mod_q};
    sub2 = {1'b0, sum} - {2'b00, mod_q, 1'b0};
    if (!sub2[W+2]) begin
      step = sub2[W-1:0];
    end else if (!sub1[W+2]) begin
      step = sub1[W-1:0];
    end else begin
      step = sum[W-1:0];
    end
  end

  // register updates
  always_comb begin
    acc_d     = acc_q;
    b_d       = b_q;
    cnt_d     = cnt_q;
    sq_d      = sq_q;
    res_d     = res_q;
    exp_d     = exp_q;
    special_d = special_q;
    err_d     = err_q;
    if (cmd_i.load) begin
      acc_d     = '0;
      b_d       = base_in;
      cnt_d     = mexp_pkg::CntW'(W - 1);
      exp_d     = exp_in;
      special_d = exp_zero | mod_zero;
      err_d     = !exp_zero && mod_zero;
      // one when exponent is zero, else 1 mod m, which is 0 for m of 0 or 1
      res_d     = {{(W-1){1'b0}}, exp_zero | (mod_in > W'(1))};
    end else if (cmd_i.setup) begin
      acc_d = '0;
      b_d   = sq_q;
      cnt_d = mexp_pkg::CntW'(W - 1);
    end else if (cmd_i.iterate) begin
      acc_d = step;
      b_d   = {b_q[W-2:0], 1'b0};
      cnt_d = cnt_q - mexp_pkg::CntW'(1);
      if (cnt_q == '0) begin
        case (cmd_i.op)
          mexp_pkg::OP_REDUCE: sq_d = step;
          mexp_pkg::OP_MUL_R: begin
            res_d    = step;
            exp_d[0] = 1'b0;
          end
          mexp_pkg::OP_MUL_S: begin
            sq_d  = step;
            exp_d = {1'b0, exp_q[W-1:1]};
          end
          default: ;
        endcase
      end
    end
  end

  // control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      special_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      special_q <= special_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    b_q   <= b_d;
    sq_q  <= sq_d;
    res_q <= res_d;
    exp_q <= exp_d;
    err_q <= err_d;
    if (cmd_i.load) begin
      mod_q <= mod_in;
    end
    if (cmd_i.out_load) begin
      out_res_q <= res_q;
      out_err_q <= err_q;
    end
  end

  assign sts_o.special  = special_q;
  assign sts_o.last     = (cnt_q == '0);
  assign sts_o.exp_lsb  = exp_q[0];
  assign sts_o.exp_more = (exp_q[W-1:1] != '0);

  assign power_result_o       = out_res_q;
  assign zero_modulus_error_o = out_err_q;

`ifndef ASSERT_OFF
  // accumulator stays reduced while multiplying
  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.iterate && (cmd_i.op == mexp_pkg::OP_MUL_R || cmd_i.op == mexp_pkg::OP_MUL_S))
    |-> (acc_q < mod_q))
    else $error("accumulator not below modulus");

  // square operand is reduced before any multiply
  a_sq_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.iterate && (cmd_i.op == mexp_pkg::OP_MUL_R || cmd_i.op == mexp_pkg::OP_MUL_S))
    |-> (sq_q < mod_q))
    else $error("square not below modulus");

  // running result is reduced when it is an operand
  a_res_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.iterate && cmd_i.op == mexp_pkg::OP_MUL_R) |-> (res_q < mod_q))
    else $error("result not below modulus");
`endif

endmodule

// File: hdl/mexp_ctrl.sv
module mexp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mexp_pkg::cmd_t cmd_o,
  input  mexp_pkg::sts_t sts_i
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_REDUCE = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_MUL_R  = 6'b001000,
    ST_MUL_S  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '{load: 1'b0, setup: 1'b0, iterate: 1'b0,
                op: mexp_pkg::OP_NONE, out_load: 1'b0};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (sts_i.special) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.iterate = 1'b1;
          cmd_o.op      = mexp_pkg::OP_REDUCE;
          if (sts_i.last) begin
            state_d = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        cmd_o.setup = 1'b1;
        if (sts_i.exp_lsb) begin
          state_d = ST_MUL_R;
        end else if (sts_i.exp_more) begin
          state_d = ST_MUL_S;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_MUL_R: begin
        cmd_o.iterate = 1'b1;
        cmd_o.op      = mexp_pkg::OP_MUL_R;
        if (sts_i.last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_MUL_S: begin
        cmd_o.iterate = 1'b1;
        cmd_o.op      = mexp_pkg::OP_MUL_S;
        if (sts_i.last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register valid
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  // a finished result is never dropped by a new one
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

  // loading the output always presents it next cycle
  a_out_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("loaded result not presented");

  // a new request starts the reduce pass
  a_load_reduce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_REDUCE))
    else $error("request did not start reduction");
`endif

endmodule
